### rtl/core/ssfe_pkg.sv
`default_nettype none
package ssfe_pkg;

   localparam int MAX_TERMS_DEF  = 16;
   localparam int ANGLE_BITS_DEF = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [1:0] CSR_WAVENUMBER = 2'd0;
   localparam logic [1:0] CSR_AMPLITUDE  = 2'd1;
   localparam logic [1:0] CSR_TERM_COUNT = 2'd2;

   typedef struct packed {
      logic [7:0]         wavenumber;
      logic signed [15:0] amplitude;
      logic [4:0]         term_count;
   } cfg_type;

   typedef struct packed {
      logic               is_eval;
      logic               load_ok;
      logic [3:0]         coeff_index;
      logic signed [15:0] coeff_value;
      logic [15:0]        eta_angle;
      logic [15:0]        phi_angle;
   } item_type;

endpackage
`default_nettype wire

### rtl/core/sine_series_field_eval_core.sv
`default_nettype none
// sine series field evaluator
// request channel: start with req_* fields is taken when busy is low.
//   req_op selects a coefficient load (req_coeff_index, req_coeff_value)
//   or a point evaluation (req_eta_angle, req_phi_angle).
// a two-entry queue sits between the front end and the evaluation engine,
//   so busy rises only when two requests are waiting.
// loads are written from the idle state and give no response.
// an evaluation gives one response, rsp_strobe high for one cycle with
//   rsp_velocity, after the single sine / multiply-accumulate pipeline
//   that handles one term per cycle, its drain, and the final multiply
//   split into a low and a high half.
// the engine runs one request at a time and pops only in the idle state;
//   loads, which stay in idle, can be popped back to back.
// configuration: csr_valid/csr_ready with csr_index and csr_wdata;
//   csr_ready is always high. write only while idle.
// reset clears the queue, the engine, the coefficient table (all zero)
//   and the registers to wavenumber 1, amplitude 0, term_count 0.
// the receiver cannot stall; responses are never held.
module sine_series_field_eval_core #(
   parameter int MAX_TERMS  = ssfe_pkg::MAX_TERMS_DEF,
   parameter int ANGLE_BITS = ssfe_pkg::ANGLE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_op,
   input  wire logic [3:0]         req_coeff_index,
   input  wire logic signed [15:0] req_coeff_value,
   input  wire logic [15:0]        req_eta_angle,
   input  wire logic [15:0]        req_phi_angle,
   output logic                    rsp_strobe,
   output logic signed [24:0]      rsp_velocity,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   ssfe_pkg::cfg_type  cfg_ff;
   ssfe_pkg::item_type head;
   logic               head_valid, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wavenumber <= 8'd1;
         cfg_ff.amplitude  <= 16'sd0;
         cfg_ff.term_count <= 5'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ssfe_pkg::CSR_WAVENUMBER: cfg_ff.wavenumber <= csr_wdata[7:0];
            ssfe_pkg::CSR_AMPLITUDE:  cfg_ff.amplitude  <= $signed(csr_wdata);
            ssfe_pkg::CSR_TERM_COUNT: cfg_ff.term_count <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   ssfe_front #(.MAX_TERMS(MAX_TERMS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .req_eta_angle   (req_eta_angle),
      .req_phi_angle   (req_phi_angle),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop)
   );

   ssfe_back #(.MAX_TERMS(MAX_TERMS), .ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_velocity (rsp_velocity)
   );

endmodule
`default_nettype wire

### rtl/core/ssfe_ram.sv
`default_nettype none
module ssfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

### rtl/core/ssfe_front.sv
`default_nettype none
module ssfe_front #(
   parameter int MAX_TERMS = ssfe_pkg::MAX_TERMS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_op,
   input  wire logic [3:0]         req_coeff_index,
   input  wire logic signed [15:0] req_coeff_value,
   input  wire logic [15:0]        req_eta_angle,
   input  wire logic [15:0]        req_phi_angle,
   output logic                    head_valid,
   output ssfe_pkg::item_type      head,
   input  wire logic               pop
);

   ssfe_pkg::item_type q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   ssfe_pkg::item_type item;

   assign busy       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rp_ff];
   assign push       = start && !busy;

   always_comb begin
      item.is_eval     = (req_op == ssfe_pkg::OP_EVAL);
      // loads to slots past the table are dropped by the back end
      item.load_ok     = (7'(req_coeff_index) < 7'(MAX_TERMS));
      item.coeff_index = req_coeff_index;
      item.coeff_value = req_coeff_value;
      item.eta_angle   = req_eta_angle;
      item.phi_angle   = req_phi_angle;
   end

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= item;
      end
   end

endmodule
`default_nettype wire

### rtl/core/ssfe_back.sv
`default_nettype none
module ssfe_back #(
   parameter int MAX_TERMS  = ssfe_pkg::MAX_TERMS_DEF,
   parameter int ANGLE_BITS = ssfe_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ssfe_pkg::cfg_type   cfg,
   input  wire logic                head_valid,
   input  wire ssfe_pkg::item_type  head,
   output logic                     pop,
   output logic                     rsp_strobe,
   output logic signed [24:0]       rsp_velocity
);

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int ACC_W = 32 + $clog2(MAX_TERMS);
   localparam int LO_W  = 19;
   localparam int HI_W  = ACC_W - LO_W;
   localparam int PW    = ACC_W + 17;
   localparam int AB    = ANGLE_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TERMS = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_MLO   = 3'd3;
   localparam logic [2:0] ST_MHI   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   localparam logic signed [PW-1:0] RND    = PW'(1) << 25;
   localparam logic signed [PW-1:0] VEL_HI = PW'(25'sh0FFFFFF);
   localparam logic signed [PW-1:0] VEL_LO = -(PW'(1) << 24);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in, terms_ff, terms_in;
   logic [AB-1:0]    ang_ff, ang_in, step_ff, step_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [16:0]      e_ff;
   logic signed [LO_W+16:0] prod_lo_ff;
   logic signed [HI_W+16:0] prod_hi_ff;
   logic                    rsp_strobe_ff;
   logic signed [24:0]      rsp_vel_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   // coefficient table and its valid bits
   logic [MAX_TERMS-1:0] vld_ff;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   logic [15:0]          ram_rdata;
   logic                 rd_ok_ff;

   assign ram_waddr = IDX_W'(7'(head.coeff_index));
   assign ram_raddr = n_ff[IDX_W-1:0];

   ssfe_ram #(.WIDTH(16), .DEPTH(MAX_TERMS)) u_coeff_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (head.coeff_value),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ram_we) begin
         vld_ff[ram_waddr] <= 1'b1;
      end
      rd_ok_ff <= vld_ff[ram_raddr];
   end

   // angle setup
   logic [AB-1:0]   eta_m, phi_m, eta_ang;
   logic [AB+7:0]   eta_prod;
   logic [6:0]      tc7, mt7;

   assign eta_m    = AB'(head.eta_angle);
   assign phi_m    = AB'(head.phi_angle);
   assign eta_prod = (AB+8)'(cfg.wavenumber) * (AB+8)'(eta_m);
   assign eta_ang  = eta_prod[AB-1:0];
   assign tc7      = 7'(cfg.term_count);
   assign mt7      = 7'(MAX_TERMS);

   // issue into the sine pipeline
   logic          iss_v, iss_eta;
   logic [AB-1:0] iss_ang;
   logic [15:0]   phase;

   generate
      if (AB >= 16) begin : g_phase_dn
         assign phase = 16'(iss_ang >> (AB - 16));
      end else begin : g_phase_up
         assign phase = {iss_ang, {(16 - AB){1'b0}}};
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      terms_in = terms_ff;
      ang_in   = ang_ff;
      step_in  = step_ff;
      pop      = 1'b0;
      ram_we   = 1'b0;
      iss_v    = 1'b0;
      iss_eta  = 1'b0;
      iss_ang  = ang_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head.is_eval) begin
                  iss_v    = 1'b1;
                  iss_eta  = 1'b1;
                  iss_ang  = eta_ang;
                  step_in  = {phi_m[AB-2:0], 1'b0};
                  ang_in   = {phi_m[AB-2:0], 1'b0};
                  n_in     = '0;
                  terms_in = CNT_W'((tc7 > mt7) ? mt7 : tc7);
                  state_in = (terms_in == '0) ? ST_DRAIN : ST_TERMS;
               end else begin
                  ram_we = head.load_ok;
               end
            end
         end
         ST_TERMS: begin
            iss_v  = 1'b1;
            ang_in = ang_ff + step_ff;
            n_in   = n_ff + 1'b1;
            if (n_in == terms_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff || v6_ff)) begin
               state_in = ST_MLO;
            end
         end
         ST_MLO:  state_in = ST_MHI;
         ST_MHI:  state_in = ST_FIN;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sine pipeline
   logic        e1_ff, e2_ff, e3_ff, e4_ff, e5_ff, e6_ff;
   logic [14:0] x1_ff, x2_ff, x3_ff, x4_ff;
   logic [1:0]  q1_ff, q2_ff, q3_ff, q4_ff;
   logic [14:0] sq2_ff, sq3_ff;
   logic [13:0] d3_ff;
   logic [14:0] t4_ff;
   logic signed [15:0] c2_ff, c3_ff, c4_ff, c5_ff;
   logic signed [15:0] sn5_ff;
   logic signed [31:0] p6_ff;

   logic [14:0] x0;
   logic [29:0] m_sq;
   logic [25:0] m_t1;
   logic [28:0] m_t2;
   logic [29:0] m_r;
   logic [16:0] s2;
   logic [15:0] s_sat;
   logic signed [15:0] mul_a;
   logic signed [32:0] e_sum;

   assign x0    = phase[14] ? 15'(15'd16384 - 15'(phase[13:0])) : 15'(phase[13:0]);
   assign m_sq  = 30'(x1_ff) * 30'(x1_ff);
   assign m_t1  = 26'(sq2_ff) * 26'd1160;
   assign m_t2  = 29'(d3_ff) * 29'(sq3_ff);
   assign m_r   = 30'(x4_ff) * 30'(t4_ff);
   assign s2    = {m_r[29:14], 1'b0};
   assign s_sat = (s2 > 17'd32767) ? 16'd32767 : s2[15:0];
   assign mul_a = e5_ff ? cfg.amplitude : c5_ff;
   assign e_sum = 33'(p6_ff) + 33'sd16384;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= iss_v;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff  <= iss_eta;
      x1_ff  <= x0;
      q1_ff  <= phase[15:14];
      e2_ff  <= e1_ff;
      x2_ff  <= x1_ff;
      q2_ff  <= q1_ff;
      sq2_ff <= m_sq[28:14];
      // read data lines up with the item in stage one
      c2_ff  <= rd_ok_ff ? $signed(ram_rdata) : 16'sd0;
      e3_ff  <= e2_ff;
      x3_ff  <= x2_ff;
      q3_ff  <= q2_ff;
      sq3_ff <= sq2_ff;
      d3_ff  <= 14'(14'd10512 - 14'(m_t1[25:14]));
      c3_ff  <= c2_ff;
      e4_ff  <= e3_ff;
      x4_ff  <= x3_ff;
      q4_ff  <= q3_ff;
      t4_ff  <= 15'(15'd25736 - m_t2[28:14]);
      c4_ff  <= c3_ff;
      e5_ff  <= e4_ff;
      sn5_ff <= q4_ff[1] ? -$signed(s_sat) : $signed(s_sat);
      c5_ff  <= c4_ff;
      e6_ff  <= e5_ff;
      p6_ff  <= mul_a * sn5_ff;
   end

   // accumulate and final scaling
   logic signed [PW-1:0] tot, vel_w;

   assign tot   = (PW'(prod_hi_ff) <<< LO_W) + PW'(prod_lo_ff) + RND;
   assign vel_w = tot >>> 26;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && head_valid && head.is_eval) begin
         acc_ff <= '0;
      end else if (v6_ff && !e6_ff) begin
         acc_ff <= acc_ff + ACC_W'(p6_ff);
      end
      if (v6_ff && e6_ff) begin
         e_ff <= 17'(e_sum >>> 15);
      end
      if (state_ff == ST_MLO) begin
         prod_lo_ff <= $signed({1'b0, acc_ff[LO_W-1:0]}) * e_ff;
      end
      if (state_ff == ST_MHI) begin
         prod_hi_ff <= $signed(acc_ff[ACC_W-1:LO_W]) * e_ff;
      end
      if (state_ff == ST_FIN) begin
         priority if (vel_w > VEL_HI) begin
            rsp_vel_ff <= 25'sh0FFFFFF;
         end else if (vel_w < VEL_LO) begin
            rsp_vel_ff <= -25'sh1000000;
         end else begin
            rsp_vel_ff <= 25'(vel_w);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_FIN);
      end
      n_ff     <= n_in;
      terms_ff <= terms_in;
      ang_ff   <= ang_in;
      step_ff  <= step_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_velocity = rsp_vel_ff;

endmodule
`default_nettype wire

### rtl/core/ssfe_checker.sv
`default_nettype none
module ssfe_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe
);

   // the engine goes through its final states and back to idle between evaluations
   a_no_back_to_back_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe in two consecutive cycles");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("busy or response right after reset");

   // queue fills only by taking a request
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted request");

endmodule

bind sine_series_field_eval_core ssfe_checker u_ssfe_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
module tb_top;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int DRAIN_CYCLES = 48;

   typedef struct {
      logic               op;
      logic [3:0]         coeff_index;
      logic signed [15:0] coeff_value;
      logic [15:0]        eta_angle;
      logic [15:0]        phi_angle;
   } req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = 1'b0;
   logic [3:0] req_coeff_index = '0;
   logic signed [15:0] req_coeff_value = '0;
   logic [15:0] req_eta_angle = '0;
   logic [15:0] req_phi_angle = '0;
   logic rsp_strobe;
   logic signed [24:0] rsp_velocity;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   sine_series_field_eval_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_coeff_index(req_coeff_index),
      .req_coeff_value(req_coeff_value), .req_eta_angle(req_eta_angle),
      .req_phi_angle(req_phi_angle), .rsp_strobe(rsp_strobe),
      .rsp_velocity(rsp_velocity), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the block state
   logic [7:0]         sh_wavenumber;
   logic signed [15:0] sh_amplitude;
   logic [4:0]         sh_term_count;
   logic signed [15:0] sh_coeff [16];

   req_type pending_req[$];
   logic signed [24:0] velocity_expect[$];
   int mismatches = 0;
   int n_loads = 0;
   int n_evals = 0;
   int n_checked = 0;
   logic hold = 1'b1;

   function automatic longint sine_q15(longint unsigned angle);
      logic [15:0] phase;
      longint x, x2, t, r;
      phase = angle[15:0];
      x = phase[14] ? (16384 - longint'(phase[13:0])) : longint'(phase[13:0]);
      x2 = (x * x) >>> 14;
      t = (1160 * x2) >>> 14;
      t = ((10512 - t) * x2) >>> 14;
      t = 25736 - t;
      r = (x * t) >>> 14;
      r = r * 2;
      if (r > 32767) r = 32767;
      return phase[15] ? -r : r;
   endfunction

   function automatic logic signed [24:0] predict_velocity(logic [15:0] eta,
                                                           logic [15:0] phi);
      longint acc, e, v;
      int terms;
      acc = 0;
      terms = (sh_term_count > 16) ? 16 : int'(sh_term_count);
      for (int n = 1; n <= terms; n++)
         acc += longint'(sh_coeff[n-1]) * sine_q15(longint'(2 * n) * longint'(phi));
      e = (longint'(sh_amplitude) * sine_q15(longint'(sh_wavenumber) * longint'(eta))
           + 16384) >>> 15;
      v = (acc * e + (longint'(1) << 25)) >>> 26;
      if (v > 16777215) v = 16777215;
      if (v < -16777216) v = -16777216;
      return v[24:0];
   endfunction

   // driver: bursts of requests with random gaps
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      req_type nx;
      logic take;
      if (reset) begin
         start <= 1'b0;
      end else begin
         take = 1'b0;
         if (start && !busy) begin
            if (req_op == ssfe_pkg::OP_LOAD) begin
               n_loads++;
               if (req_coeff_index < 16) sh_coeff[req_coeff_index] = req_coeff_value;
            end else begin
               n_evals++;
               velocity_expect.push_back(predict_velocity(req_eta_angle, req_phi_angle));
            end
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 10);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            take = (gap_left == 0);
         end else if (!start) begin
            if (gap_left > 0) gap_left--;
            take = (gap_left == 0);
         end
         if (start && busy) begin
            // request still waiting, keep it on the port
         end else if (take && !hold && pending_req.size() > 0) begin
            nx = pending_req.pop_front();
            req_op <= nx.op;
            req_coeff_index <= nx.coeff_index;
            req_coeff_value <= nx.coeff_value;
            req_eta_angle <= nx.eta_angle;
            req_phi_angle <= nx.phi_angle;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic signed [24:0] want;
      if (!reset && rsp_strobe) begin
         if (velocity_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: velocity %0d", rsp_velocity);
         end else begin
            want = velocity_expect.pop_front();
            n_checked++;
            if (rsp_velocity !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("velocity mismatch: expected %0d actual %0d", want, rsp_velocity);
            end
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         ssfe_pkg::CSR_WAVENUMBER: sh_wavenumber = val[7:0];
         ssfe_pkg::CSR_AMPLITUDE:  sh_amplitude = val;
         ssfe_pkg::CSR_TERM_COUNT: sh_term_count = val[4:0];
         default: ;
      endcase
   endtask

   task automatic push_req(logic op, logic [3:0] idx, logic [15:0] val,
                           logic [15:0] eta, logic [15:0] phi);
      req_type r;
      r.op = op; r.coeff_index = idx; r.coeff_value = val;
      r.eta_angle = eta; r.phi_angle = phi;
      pending_req.push_back(r);
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h8000;
         3: return 16'h7fff;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // let every request finish, including trailing loads
   task automatic run_and_drain();
      hold = 1'b0;
      while (pending_req.size() != 0 || start) @(posedge clock);
      hold = 1'b1;
      while (velocity_expect.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 3)
            push_req(ssfe_pkg::OP_LOAD, 4'($urandom_range(0, 15)), pick16(), pick16(),
                     pick16());
         else
            push_req(ssfe_pkg::OP_EVAL, 4'($urandom_range(0, 15)), pick16(), pick16(),
                     pick16());
      end
      run_and_drain();
   endtask

   initial begin
      sh_wavenumber = 8'd1;
      sh_amplitude = '0;
      sh_term_count = '0;
      for (int i = 0; i < 16; i++) sh_coeff[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state: zero terms and zero amplitude
      push_req(ssfe_pkg::OP_EVAL, 4'hf, 16'h7fff, 16'h4000, 16'h1234);
      run_and_drain();

      csr_write(ssfe_pkg::CSR_WAVENUMBER, 16'h0001);
      csr_write(ssfe_pkg::CSR_AMPLITUDE, 16'h7fff);
      csr_write(ssfe_pkg::CSR_TERM_COUNT, 16'd16);
      csr_write(CSR_SPARE, 16'hffff);
      for (int i = 0; i < 16; i++)
         push_req(ssfe_pkg::OP_LOAD, 4'(i), (i % 2) ? 16'h7fff : 16'h8000, 16'hffff,
                  16'hffff);
      push_req(ssfe_pkg::OP_EVAL, 4'h0, 16'h0000, 16'h0000, 16'h0000);
      push_req(ssfe_pkg::OP_EVAL, 4'hf, 16'hffff, 16'h4000, 16'h0800);
      push_req(ssfe_pkg::OP_EVAL, 4'h0, 16'h0000, 16'h8000, 16'h2000);
      push_req(ssfe_pkg::OP_EVAL, 4'h5, 16'h1111, 16'hc000, 16'hffff);
      push_req(ssfe_pkg::OP_EVAL, 4'ha, 16'h8000, 16'hffff, 16'h7fff);
      push_req(ssfe_pkg::OP_EVAL, 4'h3, 16'h7fff, 16'h2000, 16'h8000);
      run_and_drain();

      csr_write(ssfe_pkg::CSR_TERM_COUNT, 16'd31);
      csr_write(ssfe_pkg::CSR_AMPLITUDE, 16'h8000);
      csr_write(ssfe_pkg::CSR_WAVENUMBER, 16'h00ff);
      random_phase(70);

      csr_write(ssfe_pkg::CSR_WAVENUMBER, 16'h0000);
      csr_write(ssfe_pkg::CSR_TERM_COUNT, 16'd0);
      random_phase(40);

      csr_write(ssfe_pkg::CSR_WAVENUMBER, 16'hff01);
      csr_write(ssfe_pkg::CSR_AMPLITUDE, 16'h7fff);
      csr_write(ssfe_pkg::CSR_TERM_COUNT, 16'd1);
      random_phase(60);

      for (int k = 0; k < 5; k++) begin
         csr_write(ssfe_pkg::CSR_WAVENUMBER, 16'($urandom_range(0, 65535)));
         csr_write(ssfe_pkg::CSR_AMPLITUDE, 16'($urandom_range(0, 65535)));
         csr_write(ssfe_pkg::CSR_TERM_COUNT, 16'($urandom_range(0, 31)));
         csr_write(CSR_SPARE, 16'($urandom_range(0, 65535)));
         random_phase(60);
      end

      $display("covered %0d coefficient loads and %0d point evaluations, %0d responses checked",
               n_loads, n_evals, n_checked);
      $display("register settings included extreme wavenumber, amplitude and term counts");
      if (mismatches == 0 && velocity_expect.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire
